// ===== src/iprt_pkg.sv =====
// Shared types and constants for the ID-to-PID register table.
`default_nettype none
package iprt_pkg;

    localparam int APP_W = 32;
    localparam int PID_W = 31;

    // Result kind carried on the output tuser
    typedef enum logic [1:0] {
        OUT_UPDATED = 2'd0,
        OUT_CLAIMED = 2'd1,
        OUT_FULL    = 2'd2
    } t_outcome;

    // One registration request
    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [APP_W-1:0] app;
    } t_item;

    // Back-end sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_WR   = 4'b1000
    } t_state;

endpackage
`default_nettype wire

// ===== src/id_to_pid_register_table.sv =====
// Top level of the ID-to-PID register table.
// An item passes the input queue, then the back-end compare, select and write states.
// The back end takes no new item until its idle/compare/select/write sequence is done.
// A two-entry input queue and an output register let both sides stall on their own.
// Reset (synchronous, active low) marks every table entry unused and empties queue and output.
`default_nettype none
module id_to_pid_register_table #(
    parameter int ENTRIES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [31:0] app_id, [62:32] proc_id, [63] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] proc_id_out, [31] zero
    output logic [1:0]  m_axis_tuser    // [1:0] outcome
);
    import iprt_pkg::*;

    t_item            w_in_item;
    t_item            w_q_item;
    logic             w_q_valid;
    logic             w_q_ready;
    t_outcome         w_kind;
    logic [PID_W-1:0] w_pid;

    assign w_in_item.app = s_axis_tdata[APP_W-1:0];
    assign w_in_item.pid = s_axis_tdata[APP_W+PID_W-1:APP_W];

    // input queue
    iprt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // table search and update
    iprt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_item      (w_q_item),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (w_kind),
        .o_out_pid   (w_pid)
    );

    assign m_axis_tdata = {1'b0, w_pid};
    assign m_axis_tuser = w_kind;

endmodule
`default_nettype wire

// ===== src/iprt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iprt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                       i_wdata,
    input  wire                                   i_re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/iprt_front.sv =====
// Front end: accepts request items into a two-entry queue.
`default_nettype none
module iprt_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  iprt_pkg::t_item      i_item,
    output logic                 o_valid,
    input  wire                  i_ready,
    output iprt_pkg::t_item      o_item
);
    import iprt_pkg::*;

    t_item       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        w_push;
    logic        w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/iprt_back.sv =====
// Back end: match/free search over the table, update and result register.
`default_nettype none
module iprt_back #(
    parameter int ENTRIES = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  iprt_pkg::t_item                  i_item,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output iprt_pkg::t_outcome               o_out_kind,
    output logic [iprt_pkg::PID_W-1:0]       o_out_pid
);
    import iprt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_state             r_state;
    logic [APP_W-1:0]   r_app;
    logic [PID_W-1:0]   r_pid;
    logic [ENTRIES-1:0] r_used;
    logic [APP_W-1:0]   r_cell_app [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_free;
    logic [IW-1:0]      w_hit_idx;
    logic [IW-1:0]      w_free_idx;
    t_outcome           r_kind;
    logic [IW-1:0]      r_idx;
    logic               w_out_free;
    logic               w_commit;
    logic               w_ram_we;
    logic [PID_W-1:0]   w_ram_rdata;
    logic               r_out_valid;
    t_outcome           r_out_kind;
    logic [PID_W-1:0]   r_out_pid;

    assign o_ready     = (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == ST_WR) && w_out_free;
    assign w_ram_we    = w_commit && (r_kind != OUT_FULL);
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_pid   = r_out_pid;

    // parallel compare, one comparator per entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_used[i] && (r_cell_app[i] == r_app);
        end
    end

    // lowest-index priority encoders over the registered vectors
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_idx = IW'(i);
            end
            if (r_free[i]) begin
                w_free_idx = IW'(i);
            end
        end
    end

    // process ID storage, read at the hit index
    iprt_ram #(
        .WIDTH (PID_W),
        .DEPTH (ENTRIES)
    ) u_pid_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_pid),
        .i_re    (r_state == ST_SEL),
        .i_raddr (w_hit_idx),
        .o_rdata (w_ram_rdata)
    );

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load on commit, clear once taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_state <= ST_SEL;
                end
                ST_SEL: begin
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    if (w_out_free) begin
                        if (r_kind == OUT_CLAIMED) begin
                            r_used[r_idx] <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_valid) begin
            r_app <= i_item.app;
            r_pid <= i_item.pid;
        end
        if (r_state == ST_CMP) begin
            r_match <= w_match;
            r_free  <= ~r_used;
        end
        if (r_state == ST_SEL) begin
            if (|r_match) begin
                r_kind <= OUT_UPDATED;
                r_idx  <= w_hit_idx;
            end else if (|r_free) begin
                r_kind <= OUT_CLAIMED;
                r_idx  <= w_free_idx;
            end else begin
                r_kind <= OUT_FULL;
                r_idx  <= w_free_idx;
            end
        end
        if (w_commit) begin
            r_out_kind <= r_kind;
            unique case (r_kind)
                OUT_UPDATED: r_out_pid <= w_ram_rdata;
                OUT_CLAIMED: r_out_pid <= r_pid;
                default:     r_out_pid <= '0;
            endcase
            if (r_kind == OUT_CLAIMED) begin
                r_cell_app[r_idx] <= r_app;
            end
        end
    end

endmodule
`default_nettype wire
